// ===== hw/rtl/touch_key_region_map_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the touch key region map
// Shorthand for the clocked, reset-qualified properties used by the checker.
// ---------------------------------------------------------------------------
`ifndef TOUCH_KEY_REGION_MAP_TOP_ASSERT_SVH
`define TOUCH_KEY_REGION_MAP_TOP_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define TKRM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("touch key region map: next-cycle property failed");

// The consequent must hold in the same cycle as the antecedent.
`define TKRM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("touch key region map: same-cycle property failed");

`endif

// ===== hw/rtl/tkrm_pkg.sv =====
// ---------------------------------------------------------------------------
// Touch key region map package
// Shared constants, state encoding and controller/datapath interface types.
// ---------------------------------------------------------------------------
package tkrm_pkg;

    // Default store geometry and key codes.
    localparam int DEF_MAX_COLS      = 64;
    localparam int DEF_MAX_ROWS      = 64;
    localparam int DEF_KEY_BITS      = 8;
    localparam int DEF_NONE_CODE     = 0;
    localparam int DEF_NOCHANGE_CODE = 255;

    // Fixed field widths.
    localparam int COORD_W = 16;
    localparam int KEY_W   = 8;
    localparam int GRID_W  = 7;
    localparam int CFG_IDX_W = 8;

    // Register reset values.
    localparam logic [GRID_W-1:0] GRID_WIDTH_RST  = 7'd64;
    localparam logic [GRID_W-1:0] GRID_HEIGHT_RST = 7'd64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 8'd1;

    // Command codes.
    localparam logic CMD_FILL   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_LOOK_READ,
        ST_LOOK_DONE
    } tkrm_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic fill_step;
        logic read_step;
        logic out_load;
    } tkrm_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic clear_last;
        logic fill_go;
        logic fill_last;
        logic out_free;
    } tkrm_status_t;

endpackage

// ===== hw/rtl/tkrm_ctrl.sv =====
// ---------------------------------------------------------------------------
// Touch key region map controller
// Sequences the clearing pass, rectangle fills and point lookups.
// ---------------------------------------------------------------------------
module tkrm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  command,
    input  tkrm_pkg::tkrm_status_t status,
    output tkrm_pkg::tkrm_cmd_t    cmd
);
    import tkrm_pkg::*;

    tkrm_state_t state_reg;
    tkrm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == CMD_LOOKUP)
                    begin
                        state_next = ST_LOOK_READ;
                    end
                    else if (status.fill_go)
                    begin
                        state_next = ST_FILL;
                    end
                end
            end
            ST_FILL:
            begin
                if (status.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOOK_READ:
            begin
                state_next = ST_LOOK_DONE;
            end
            ST_LOOK_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd.clear_step = 1'b0;
        cmd.accept     = 1'b0;
        cmd.fill_step  = 1'b0;
        cmd.read_step  = 1'b0;
        cmd.out_load   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
            end
            ST_LOOK_READ:
            begin
                cmd.read_step = 1'b1;
            end
            ST_LOOK_DONE:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/tkrm_datapath.sv =====
// ---------------------------------------------------------------------------
// Touch key region map datapath
// Cell store, clipping, fill walk counters, lookup address and result word.
// ---------------------------------------------------------------------------
module tkrm_datapath #(
    parameter int MAX_COLS      = tkrm_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS      = tkrm_pkg::DEF_MAX_ROWS,
    parameter int KEY_BITS      = tkrm_pkg::DEF_KEY_BITS,
    parameter int NONE_CODE     = tkrm_pkg::DEF_NONE_CODE,
    parameter int NOCHANGE_CODE = tkrm_pkg::DEF_NOCHANGE_CODE
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [tkrm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tkrm_pkg::GRID_W-1:0]         cfg_data,
    input  logic                                command,
    input  logic signed [tkrm_pkg::COORD_W-1:0] rect_left,
    input  logic signed [tkrm_pkg::COORD_W-1:0] rect_top,
    input  logic signed [tkrm_pkg::COORD_W-1:0] rect_right,
    input  logic signed [tkrm_pkg::COORD_W-1:0] rect_bottom,
    input  logic [tkrm_pkg::KEY_W-1:0]          key_in,
    input  logic signed [tkrm_pkg::COORD_W-1:0] point_x,
    input  logic signed [tkrm_pkg::COORD_W-1:0] point_y,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [tkrm_pkg::KEY_W-1:0]          key_out,
    output logic                                in_bounds,
    input  tkrm_pkg::tkrm_cmd_t                 cmd,
    output tkrm_pkg::tkrm_status_t              status
);
    import tkrm_pkg::*;

    localparam int CELLS  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int COL_IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int XW     = $clog2(MAX_COLS + 1);
    localparam int YW     = $clog2(MAX_ROWS + 1);
    localparam int SW     = COORD_W + 1;

    localparam logic signed [SW-1:0]   MAX_COLS_S = SW'(MAX_COLS);
    localparam logic signed [SW-1:0]   MAX_ROWS_S = SW'(MAX_ROWS);
    localparam logic [KEY_BITS-1:0]    NONE_CELL  = KEY_BITS'(NONE_CODE);
    localparam logic [KEY_W-1:0]       NONE_KEY   = KEY_W'(NONE_CODE);
    localparam logic [KEY_W-1:0]       NOCHG_KEY  = KEY_W'(NOCHANGE_CODE);
    localparam logic [ADDR_W-1:0]      LAST_ADDR  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0]      ROW_STRIDE = ADDR_W'(MAX_COLS);

    logic [KEY_BITS-1:0] mem [CELLS];

    logic [GRID_W-1:0] grid_width_reg;
    logic [GRID_W-1:0] grid_height_reg;

    logic [ADDR_W-1:0]   clr_addr_reg;
    logic [XW-1:0]       x_reg;
    logic [XW-1:0]       left_reg;
    logic [XW-1:0]       right_reg;
    logic [YW-1:0]       y_reg;
    logic [YW-1:0]       bottom_reg;
    logic [ADDR_W-1:0]   row_base_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [ADDR_W-1:0]   look_addr_reg;
    logic                look_inb_reg;
    logic [KEY_BITS-1:0] rdata_reg;
    logic                out_valid_reg;
    logic [KEY_W-1:0]    key_out_reg;
    logic                in_bounds_reg;

    logic signed [SW-1:0] gw_s;
    logic signed [SW-1:0] gh_s;
    logic signed [SW-1:0] w_s;
    logic signed [SW-1:0] h_s;
    logic signed [SW-1:0] l_s;
    logic signed [SW-1:0] t_s;
    logic signed [SW-1:0] r_s;
    logic signed [SW-1:0] b_s;
    logic signed [SW-1:0] px_s;
    logic signed [SW-1:0] py_s;
    logic signed [SW-1:0] cl_s;
    logic signed [SW-1:0] ct_s;
    logic signed [SW-1:0] cr_s;
    logic signed [SW-1:0] cb_s;
    logic                 rect_nonempty;
    logic                 point_inb;
    logic [ROW_IW-1:0]    row_sel;
    logic [ADDR_W-1:0]    row_base;
    logic [ADDR_W-1:0]    fill_addr;
    logic                 x_end;
    logic                 y_end;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default:         grid_width_reg  <= grid_width_reg;
            endcase
        end
    end

    // The grid in use never exceeds the store.
    assign gw_s = {{(SW-GRID_W){1'b0}}, grid_width_reg};
    assign gh_s = {{(SW-GRID_W){1'b0}}, grid_height_reg};
    assign w_s  = (gw_s > MAX_COLS_S) ? MAX_COLS_S : gw_s;
    assign h_s  = (gh_s > MAX_ROWS_S) ? MAX_ROWS_S : gh_s;

    assign l_s  = SW'(rect_left);
    assign t_s  = SW'(rect_top);
    assign r_s  = SW'(rect_right);
    assign b_s  = SW'(rect_bottom);
    assign px_s = SW'(point_x);
    assign py_s = SW'(point_y);

    assign cl_s = l_s[SW-1] ? '0 : l_s;
    assign ct_s = t_s[SW-1] ? '0 : t_s;
    assign cr_s = (r_s > w_s) ? w_s : r_s;
    assign cb_s = (b_s > h_s) ? h_s : b_s;

    assign rect_nonempty = (cl_s < cr_s) && (ct_s < cb_s);
    assign point_inb     = !px_s[SW-1] && !py_s[SW-1] && (px_s < w_s) && (py_s < h_s);

    // One row multiplier serves both the fill start and the lookup address.
    assign row_sel  = (command == CMD_LOOKUP) ? py_s[ROW_IW-1:0] : ct_s[ROW_IW-1:0];
    assign row_base = ADDR_W'(row_sel) * ROW_STRIDE;

    assign fill_addr = row_base_reg + ADDR_W'(x_reg);
    assign x_end     = (XW'(x_reg + XW'(1)) == right_reg);
    assign y_end     = (YW'(y_reg + YW'(1)) == bottom_reg);

    // Clearing pass address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    // Fill walk and lookup address registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            left_reg      <= cl_s[XW-1:0];
            right_reg     <= cr_s[XW-1:0];
            x_reg         <= cl_s[XW-1:0];
            y_reg         <= ct_s[YW-1:0];
            bottom_reg    <= cb_s[YW-1:0];
            row_base_reg  <= row_base;
            key_reg       <= key_in;
            look_addr_reg <= row_base + ADDR_W'(px_s[COL_IW-1:0]);
            look_inb_reg  <= point_inb;
        end
        else if (cmd.fill_step)
        begin
            if (x_end)
            begin
                x_reg        <= left_reg;
                y_reg        <= YW'(y_reg + YW'(1));
                row_base_reg <= row_base_reg + ROW_STRIDE;
            end
            else
            begin
                x_reg <= XW'(x_reg + XW'(1));
            end
        end
    end

    // Cell store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            mem[clr_addr_reg] <= NONE_CELL;
        end
        else if (cmd.fill_step)
        begin
            mem[fill_addr] <= KEY_BITS'(key_reg);
        end
        if (cmd.read_step)
        begin
            rdata_reg <= mem[look_addr_reg];
        end
    end

    // Result word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            key_out_reg   <= look_inb_reg ? KEY_W'(rdata_reg) : NONE_KEY;
            in_bounds_reg <= look_inb_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign key_out   = key_out_reg;
    assign in_bounds = in_bounds_reg;

    assign status.clear_last = (clr_addr_reg == LAST_ADDR);
    assign status.fill_go    = (command == CMD_FILL) && (key_in != NOCHG_KEY) && rect_nonempty;
    assign status.fill_last  = x_end && y_end;
    assign status.out_free   = !out_valid_reg || out_ready;

endmodule

// ===== hw/rtl/touch_key_region_map_top.sv =====
// ---------------------------------------------------------------------------
// Touch key region map
// Grid of key codes, one per screen cell, filled by rectangles and read back
// by point lookups for touch hit-testing.
// ---------------------------------------------------------------------------
// After reset the block runs a clearing pass that writes the none code into
// every cell of the store, one cell a cycle; in_ready stays low until it ends,
// while configuration words are taken at any time. Items are then handled
// one at a time. A lookup word has its address formed at acceptance, then
// the store is read, then the result word is loaded into the output register,
// waiting there only while an earlier result word has not been taken; only
// then can the next word be taken. A fill word walks the clipped rectangle
// one cell a cycle through the single store write port; a fill that clips to
// nothing or carries the no-change code writes nothing. Fills give no result
// word. A result word stays in the output register until out_ready, and the
// next item is accepted while it waits. Cell (x, y) lives at address
// y * MAX_COLS + x, so changing the grid size keeps each stored cell at its
// own column and row.
module touch_key_region_map_top #(
    parameter int MAX_COLS      = tkrm_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS      = tkrm_pkg::DEF_MAX_ROWS,
    parameter int KEY_BITS      = tkrm_pkg::DEF_KEY_BITS,
    parameter int NONE_CODE     = tkrm_pkg::DEF_NONE_CODE,
    parameter int NOCHANGE_CODE = tkrm_pkg::DEF_NOCHANGE_CODE
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tkrm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tkrm_pkg::GRID_W-1:0]         cfg_data,
    // Input item channel.
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic signed [tkrm_pkg::COORD_W-1:0] rect_left,
    input  logic signed [tkrm_pkg::COORD_W-1:0] rect_top,
    input  logic signed [tkrm_pkg::COORD_W-1:0] rect_right,
    input  logic signed [tkrm_pkg::COORD_W-1:0] rect_bottom,
    input  logic [tkrm_pkg::KEY_W-1:0]          key_in,
    input  logic signed [tkrm_pkg::COORD_W-1:0] point_x,
    input  logic signed [tkrm_pkg::COORD_W-1:0] point_y,
    // Result channel.
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tkrm_pkg::KEY_W-1:0]          key_out,
    output logic                                in_bounds
);
    import tkrm_pkg::*;

    tkrm_cmd_t    cmd;
    tkrm_status_t status;

    // Configuration words are always taken; the register file is written at once.
    assign cfg_ready = 1'b1;

    // The controller sequences the clearing pass, fill walks and lookups.
    tkrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the store, clipping logic, counters and result word.
    tkrm_datapath #(
        .MAX_COLS      (MAX_COLS),
        .MAX_ROWS      (MAX_ROWS),
        .KEY_BITS      (KEY_BITS),
        .NONE_CODE     (NONE_CODE),
        .NOCHANGE_CODE (NOCHANGE_CODE)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .command     (command),
        .rect_left   (rect_left),
        .rect_top    (rect_top),
        .rect_right  (rect_right),
        .rect_bottom (rect_bottom),
        .key_in      (key_in),
        .point_x     (point_x),
        .point_y     (point_y),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .key_out     (key_out),
        .in_bounds   (in_bounds),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ===== hw/rtl/tkrm_checker.sv =====
// ---------------------------------------------------------------------------
// Touch key region map checker
// Port-level properties of the block, bound to the top level.
// ---------------------------------------------------------------------------
`include "touch_key_region_map_top_assert.svh"

module tkrm_checker #(
    parameter int NONE_CODE = tkrm_pkg::DEF_NONE_CODE
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       command,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [tkrm_pkg::KEY_W-1:0] key_out,
    input logic                       in_bounds
);
    import tkrm_pkg::*;

    // A result word that is not taken holds its value.
    `TKRM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(key_out) && $stable(in_bounds))

    // A point outside the grid reports the none code.
    `TKRM_ASSERT_NOW(a_outside_none, out_valid && !in_bounds, key_out == KEY_W'(NONE_CODE))

    // An accepted lookup keeps the input side closed while the store is read.
    `TKRM_ASSERT_NEXT(a_lookup_busy, in_valid && in_ready && (command == CMD_LOOKUP), !in_ready)

endmodule

bind touch_key_region_map_top tkrm_checker #(
    .NONE_CODE (NONE_CODE)
) u_tkrm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .key_out   (key_out),
    .in_bounds (in_bounds)
);

// ===== tb/tb_touch_key_region_map_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Touch key region map testbench
// Drives fill and lookup words into the region map while a behavioral copy of
// the cell grid predicts every lookup result, and checks each result word in
// order under random sender and receiver idling and several grid sizes.
// ---------------------------------------------------------------------------
module tb_touch_key_region_map_top;

    import tkrm_pkg::*;

    localparam int MAX_COLS = DEF_MAX_COLS;
    localparam int MAX_ROWS = DEF_MAX_ROWS;
    localparam int MIRROR_AW = $clog2(MAX_COLS * MAX_ROWS);
    localparam logic [KEY_W-1:0] EMPTY_KEY = KEY_W'(DEF_NONE_CODE);
    localparam logic [KEY_W-1:0] KEEP_KEY  = KEY_W'(DEF_NOCHANGE_CODE);

    // A register index past the two real ones; the block must ignore it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_TOP = 8'hFF;

    // A fill can walk every cell of the store, and the block is only known to
    // be quiet once that much time has passed after the last result word.
    localparam int SETTLE_CYCLES = MAX_COLS * MAX_ROWS + 16;
    // Slack for the tail after every owed lookup result is back.
    localparam int TAIL_CYCLES = 32;
    // Longest legal quiet stretch is the clearing pass or a full-grid fill, plus
    // receiver stalls; the limit allows several times that.
    localparam int WATCHDOG_LIMIT = 25000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic                      cmd;
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] bottom;
        logic [KEY_W-1:0]          key;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } touch_word_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             in_grid;
    } lookup_result_t;

    // One row of the directed table. When known_result is set, the result of
    // a lookup row is typed in here instead of taken from the grid mirror.
    typedef struct packed {
        touch_word_t      word;
        logic             known_result;
        logic [KEY_W-1:0] known_key;
        logic             known_inside;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 22;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [GRID_W-1:0]         cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic                      command;
    logic signed [COORD_W-1:0] rect_left;
    logic signed [COORD_W-1:0] rect_top;
    logic signed [COORD_W-1:0] rect_right;
    logic signed [COORD_W-1:0] rect_bottom;
    logic [KEY_W-1:0]          key_in;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      out_valid;
    logic                      out_ready;
    logic [KEY_W-1:0]          key_out;
    logic                      in_bounds;

    // Behavioral copy of the grid: cell (x, y) at y * MAX_COLS + x, exactly as
    // the block addresses its store, so resizing keeps every cell in place.
    logic [KEY_W-1:0]  cell_mirror [0:MAX_COLS*MAX_ROWS-1];
    logic [GRID_W-1:0] grid_cols;
    logic [GRID_W-1:0] grid_rows;

    // Lookup results that are owed by the block, oldest first.
    lookup_result_t pending_lookups [$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int fills_sent;
    int lookups_sent;
    int inside_hits;
    int reg_writes;
    int last_left;
    int last_top;

    // Grid sizes per random phase; -1 picks a random 7-bit value.
    int phase_cols  [6] = '{127, 0, 1, 65, -1, 64};
    int phase_rows  [6] = '{40, 0, 1, 127, -1, 64};
    int phase_items [6] = '{300, 60, 60, 300, 380, 400};

    // Directed words. Lookups carry junk in their rectangle fields and fills
    // carry junk in their point fields, since the block must ignore both.
    directed_row_t directed_table [DIRECTED_ROWS] = '{
        // Fresh grid: every cell holds the none code, edges of the grid.
        '{'{CMD_LOOKUP, 16'sh7FFF, 16'sh8000, 16'sh1234, 16'shFFFF, 8'hFF, 16'sd0, 16'sd0},
          1'b1, EMPTY_KEY, 1'b1},
        '{'{CMD_LOOKUP, 16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh0040, 8'h00, 16'sd63, 16'sd63},
          1'b1, EMPTY_KEY, 1'b1},
        // Points just outside and far outside the grid.
        '{'{CMD_LOOKUP, 16'sh0000, 16'sh0000, 16'sh0040, 16'sh0040, 8'h11, -16'sd1, 16'sd0},
          1'b1, EMPTY_KEY, 1'b0},
        '{'{CMD_LOOKUP, 16'sh0000, 16'sh0000, 16'sh0040, 16'sh0040, 8'h22, 16'sd0, 16'sd64},
          1'b1, EMPTY_KEY, 1'b0},
        '{'{CMD_LOOKUP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 8'h00, 16'sh8000, 16'sh7FFF},
          1'b1, EMPTY_KEY, 1'b0},
        '{'{CMD_LOOKUP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 8'h00, 16'sh7FFF, 16'sh8000},
          1'b1, EMPTY_KEY, 1'b0},
        // Widest possible rectangle, clipped on all four sides.
        '{'{CMD_FILL, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 8'h5A, 16'sh7FFF, 16'sh8000},
          1'b0, EMPTY_KEY, 1'b0},
        '{'{CMD_LOOKUP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 8'h00, 16'sd0, 16'sd0},
          1'b0, EMPTY_KEY, 1'b0},
        // The no-change key leaves the grid alone.
        '{'{CMD_FILL, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, KEEP_KEY, 16'sd1, 16'sd1},
          1'b0, EMPTY_KEY, 1'b0},
        '{'{CMD_LOOKUP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 8'h00, 16'sd40, 16'sd20},
          1'b0, EMPTY_KEY, 1'b0},
        // Inverted and empty rectangles write nothing.
        '{'{CMD_FILL, 16'sd20, 16'sd20, 16'sd10, 16'sd10, 8'h01, 16'sd0, 16'sd0},
          1'b0, EMPTY_KEY, 1'b0},
        '{'{CMD_FILL, 16'sd5, 16'sd5, 16'sd5, 16'sd9, 8'h02, 16'sd0, 16'sd0},
          1'b0, EMPTY_KEY, 1'b0},
        // Small rectangle, then probe its corners and the exclusive edges.
        '{'{CMD_FILL, 16'sd3, 16'sd4, 16'sd6, 16'sd7, 8'hA5, 16'sd0, 16'sd0},
          1'b0, EMPTY_KEY, 1'b0},
        '{'{CMD_LOOKUP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 8'h00, 16'sd3, 16'sd4},
          1'b0, EMPTY_KEY, 1'b0},
        '{'{CMD_LOOKUP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 8'h00, 16'sd5, 16'sd6},
          1'b0, EMPTY_KEY, 1'b0},
        '{'{CMD_LOOKUP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 8'h00, 16'sd6, 16'sd6},
          1'b0, EMPTY_KEY, 1'b0},
        '{'{CMD_LOOKUP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 8'h00, 16'sd3, 16'sd7},
          1'b0, EMPTY_KEY, 1'b0},
        // Rectangle hanging off the bottom right corner.
        '{'{CMD_FILL, 16'sd60, 16'sd60, 16'sd70, 16'sd70, 8'h80, 16'sd0, 16'sd0},
          1'b0, EMPTY_KEY, 1'b0},
        '{'{CMD_LOOKUP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 8'h00, 16'sd63, 16'sd63},
          1'b0, EMPTY_KEY, 1'b0},
        // Clear: the whole grid back to the none code.
        '{'{CMD_FILL, 16'sd0, 16'sd0, 16'sd64, 16'sd64, EMPTY_KEY, 16'sd0, 16'sd0},
          1'b0, EMPTY_KEY, 1'b0},
        '{'{CMD_LOOKUP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 8'h00, 16'sd63, 16'sd63},
          1'b0, EMPTY_KEY, 1'b0},
        '{'{CMD_LOOKUP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 8'h00, 16'sd5, 16'sd6},
          1'b0, EMPTY_KEY, 1'b0}
    };

    touch_key_region_map_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .rect_left   (rect_left),
        .rect_top    (rect_top),
        .rect_right  (rect_right),
        .rect_bottom (rect_bottom),
        .key_in      (key_in),
        .point_x     (point_x),
        .point_y     (point_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .key_out     (key_out),
        .in_bounds   (in_bounds)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic record_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
    endtask

    // Apply one accepted word to the grid mirror. Fills update the mirror,
    // lookups queue the result word the block owes us.
    function automatic void apply_word(input touch_word_t w);
        int             cols;
        int             rows;
        int             lo_x;
        int             lo_y;
        int             hi_x;
        int             hi_y;
        int             x;
        int             y;
        lookup_result_t res;

        // Sizes above the store are treated as the full store.
        cols = (int'(grid_cols) > MAX_COLS) ? MAX_COLS : int'(grid_cols);
        rows = (int'(grid_rows) > MAX_ROWS) ? MAX_ROWS : int'(grid_rows);

        if (w.cmd == CMD_FILL)
        begin
            fills_sent++;
            if (w.key == KEEP_KEY)
            begin
                return;
            end
            lo_x = (w.left < 0) ? 0 : int'(w.left);
            lo_y = (w.top < 0) ? 0 : int'(w.top);
            hi_x = (w.right > cols) ? cols : int'(w.right);
            hi_y = (w.bottom > rows) ? rows : int'(w.bottom);
            for (y = lo_y; y < hi_y; y++)
            begin
                for (x = lo_x; x < hi_x; x++)
                begin
                    cell_mirror[MIRROR_AW'(y * MAX_COLS + x)] = w.key;
                end
            end
        end
        else
        begin
            lookups_sent++;
            x = int'(w.px);
            y = int'(w.py);
            if (x < 0 || y < 0 || x >= cols || y >= rows)
            begin
                res.key     = EMPTY_KEY;
                res.in_grid = 1'b0;
            end
            else
            begin
                res.key     = cell_mirror[MIRROR_AW'(y * MAX_COLS + x)];
                res.in_grid = 1'b1;
            end
            pending_lookups.push_back(res);
        end
    endfunction

    // Random word. Most fills are small rectangles near the grid so that the
    // fill walk stays short; a few are large and a few carry wild coordinates.
    // A good share of lookups land inside the most recent fill.
    function automatic touch_word_t make_random_word();
        touch_word_t w;
        int          pick;
        int          key_pick;

        w.cmd    = 1'($urandom_range(0, 1));
        w.left   = COORD_W'($urandom);
        w.top    = COORD_W'($urandom);
        w.right  = COORD_W'($urandom);
        w.bottom = COORD_W'($urandom);
        w.key    = KEY_W'($urandom);
        w.px     = COORD_W'($urandom);
        w.py     = COORD_W'($urandom);

        if (w.cmd == CMD_FILL)
        begin
            pick = $urandom_range(0, 39);
            if (pick >= 3)
            begin
                w.left   = COORD_W'(int'($urandom_range(0, 70)) - 3);
                w.top    = COORD_W'(int'($urandom_range(0, 70)) - 3);
                w.right  = COORD_W'(int'(w.left) + int'($urandom_range(0, 8)) - 1);
                w.bottom = COORD_W'(int'(w.top) + int'($urandom_range(0, 8)) - 1);
            end
            else if (pick >= 1)
            begin
                w.left   = COORD_W'(int'($urandom_range(0, 70)) - 4);
                w.top    = COORD_W'(int'($urandom_range(0, 70)) - 4);
                w.right  = COORD_W'(int'(w.left) + int'($urandom_range(0, 70)));
                w.bottom = COORD_W'(int'(w.top) + int'($urandom_range(0, 70)));
            end
            key_pick = $urandom_range(0, 15);
            if (key_pick == 0)
            begin
                w.key = KEEP_KEY;
            end
            else if (key_pick == 1)
            begin
                w.key = EMPTY_KEY;
            end
            last_left = int'(w.left);
            last_top  = int'(w.top);
        end
        else
        begin
            pick = $urandom_range(0, 9);
            if (pick >= 5)
            begin
                w.px = COORD_W'(int'($urandom_range(0, 68)) - 2);
                w.py = COORD_W'(int'($urandom_range(0, 68)) - 2);
            end
            else if (pick >= 1)
            begin
                w.px = COORD_W'(last_left + int'($urandom_range(0, 7)));
                w.py = COORD_W'(last_top + int'($urandom_range(0, 7)));
            end
        end
        return w;
    endfunction

    // Present one word and hold it until the block takes it. Within this task
    // in_valid is lowered only inside the idle loop, so back-to-back words never
    // see a low and a high scheduled in the same step.
    task automatic send_word(input touch_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= w.cmd;
        rect_left   <= w.left;
        rect_top    <= w.top;
        rect_right  <= w.right;
        rect_bottom <= w.bottom;
        key_in      <= w.key;
        point_x     <= w.px;
        point_y     <= w.py;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        apply_word(w);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GRID_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        if (idx == CFG_GRID_WIDTH)
        begin
            grid_cols = val;
        end
        else if (idx == CFG_GRID_HEIGHT)
        begin
            grid_rows = val;
        end
        reg_writes++;
        @(posedge clk);
    endtask

    // Stop sending and let every owed lookup result come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_lookups.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Make the block idle before a register write: a trailing fill produces no
    // result word, so after the last result allow a full-grid walk to finish.
    task automatic settle_block();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: random back-pressure and an in-order check of every word.
    initial
    begin
        lookup_result_t want;

        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (inside_hits >= 0 && in_bounds === 1'b1)
                begin
                    inside_hits++;
                end
                if (pending_lookups.size() == 0)
                begin
                    record_mismatch($sformatf("unexpected result word key_out=%0h in_bounds=%0b",
                                              key_out, in_bounds));
                end
                else
                begin
                    want = pending_lookups.pop_front();
                    if (key_out !== want.key)
                    begin
                        record_mismatch($sformatf("key_out expected %0h got %0h",
                                                  want.key, key_out));
                    end
                    if (in_bounds !== want.in_grid)
                    begin
                        record_mismatch($sformatf("in_bounds expected %0b got %0b",
                                                  want.in_grid, in_bounds));
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: any handshake on any channel restarts the count. The clearing
    // pass after reset and full-grid fills are the longest legal quiet spells.
    initial
    begin
        int quiet_cycles;

        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("watchdog: no handshake for %0d cycles, %0d results still owed",
                 WATCHDOG_LIMIT, pending_lookups.size());
        $display("tb_touch_key_region_map_top: done, errors");
        $finish;
    end

    // Main sequence: reset, directed table, then random phases at several
    // grid sizes and idling patterns, each phase starting from an idle block.
    initial
    begin
        int          phase;
        int          n;
        int          row;
        logic [6:0]  new_cols;
        logic [6:0]  new_rows;
        touch_word_t w;

        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_GRID_WIDTH;
        cfg_data    = '0;
        in_valid    = 1'b0;
        command     = CMD_FILL;
        rect_left   = '0;
        rect_top    = '0;
        rect_right  = '0;
        rect_bottom = '0;
        key_in      = '0;
        point_x     = '0;
        point_y     = '0;

        mismatches    = 0;
        fills_sent    = 0;
        lookups_sent  = 0;
        inside_hits   = 0;
        reg_writes    = 0;
        last_left     = 0;
        last_top      = 0;
        send_idle_pct = 9;
        recv_idle_pct = 60;
        grid_cols     = GRID_WIDTH_RST;
        grid_rows     = GRID_HEIGHT_RST;
        for (n = 0; n < MAX_COLS * MAX_ROWS; n++)
        begin
            cell_mirror[MIRROR_AW'(n)] = EMPTY_KEY;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // The first words wait out the clearing pass behind in_ready.
        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            send_word(directed_table[row].word);
            if (directed_table[row].known_result && directed_table[row].word.cmd == CMD_LOOKUP)
            begin
                void'(pending_lookups.pop_back());
                pending_lookups.push_back('{directed_table[row].known_key,
                                            directed_table[row].known_inside});
            end
        end

        for (phase = 0; phase < 6; phase++)
        begin
            // Sender lightly idle and receiver mostly stalled first, then the
            // reverse, then both sides running flat out.
            if (phase < 2)
            begin
                send_idle_pct = 9;
                recv_idle_pct = 60;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 60;
                recv_idle_pct = 9;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            settle_block();
            new_cols = (phase_cols[phase] < 0) ? 7'($urandom_range(0, 127)) : 7'(phase_cols[phase]);
            new_rows = (phase_rows[phase] < 0) ? 7'($urandom_range(0, 127)) : 7'(phase_rows[phase]);
            write_reg(CFG_GRID_WIDTH, new_cols);
            write_reg(CFG_GRID_HEIGHT, new_rows);
            if (phase == 2)
            begin
                write_reg(CFG_UNUSED_TOP, 7'h7F);
            end
            else if (phase == 4)
            begin
                write_reg(8'($urandom_range(2, 255)), 7'($urandom_range(0, 127)));
            end

            for (n = 0; n < phase_items[phase]; n++)
            begin
                w = make_random_word();
                send_word(w);
                // Now and then hold off until every owed result is back.
                if ($urandom_range(0, 59) == 0)
                begin
                    wait_for_results();
                end
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_lookups.size() != 0)
        begin
            record_mismatch($sformatf("%0d result words never arrived", pending_lookups.size()));
        end

        $display("run covered %0d fills and %0d lookups (%0d inside the grid), %0d reg writes",
                 fills_sent, lookups_sent, inside_hits, reg_writes);
        $display("grid sizes went from 0 to 127 on both axes; mismatches seen: %0d", mismatches);
        if (mismatches == 0)
        begin
            $display("tb_touch_key_region_map_top: done, clean");
        end
        else
        begin
            $display("tb_touch_key_region_map_top: done, errors");
        end
        $finish;
    end

endmodule
